FILE: design/convex_hull_2d_top_defines.svh
// Assertion macros for the convex hull checker.
`ifndef CONVEX_HULL_2D_TOP_DEFINES_SVH
`define CONVEX_HULL_2D_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define CHULL_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("convex hull check failed (same cycle)");

// Next-cycle implication, sampled on the rising clock edge.
`define CHULL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("convex hull check failed (next cycle)");

`endif

FILE: design/chull_pkg.sv
// Package for the convex hull block: sizes, command and status types.
`default_nettype none
package chull_pkg;

  localparam int MAX_POINTS  = 64;
  localparam int COORD_BITS  = 16;
  localparam int ECHO_LIMIT  = 3;
  localparam int STACK_DEPTH = 2 * MAX_POINTS;
  localparam int AW          = $clog2(MAX_POINTS);
  localparam int HAW         = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(MAX_POINTS + 1);
  localparam int TOP_W       = $clog2(STACK_DEPTH + 1);
  localparam int PT_W        = 2 * COORD_BITS;
  localparam int DIFF_W      = COORD_BITS + 1;
  localparam int PROD_W      = 2 * DIFF_W;

  // Write data source for the point store
  typedef enum logic [1:0] {
    WD_IN,
    WD_RD,
    WD_P
  } wd_src_t;

  typedef struct packed {
    logic            st_we;
    logic [AW-1:0]   st_wa;
    wd_src_t         st_wsrc;
    logic [AW-1:0]   st_ra;
    logic [HAW-1:0]  hs_ra;
    logic            p_ld;
    logic            top_clr;
    logic            push;
    logic            pop;
    logic            t2_ld;
    logic            out_ld;
    logic            out_hull;
    logic            out_last;
    logic            out_ovf;
  } chull_cmd_t;

  typedef struct packed {
    logic             lt;
    logic             pop_ok;
    logic [TOP_W-1:0] top;
  } chull_stat_t;

endpackage
`default_nettype wire

FILE: design/convex_hull_2d_top.sv
// Top level of the 2D convex hull block (monotone chain).
//
// Requests: raise start with point_x, point_y and last_point; a request is
// taken on a rising edge with start high and busy low. Busy stays low
// while loading. The request with last_point set closes the set; busy
// then rises until the final hull vertex has been sent.
// Up to 64 points are stored; further points are dropped and overflow is set
// on every vertex of that set.
// Sets of up to three points come back in input order.
// Larger sets are insertion sorted, then walked twice with a stack (lower
// and upper hull), and the hull vertices are then emitted. The single read
// port of each RAM paces these steps. Vertices come out counterclockwise
// from the lowest x/y point.
// Each vertex shows on hull_x/hull_y for one cycle with result_valid high;
// last_vertex marks the end. The receiver cannot stall.
// Reset (rst, synchronous) empties the set and returns to idle.
`default_nettype none
module convex_hull_2d_top (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    start,
  output logic                                         busy,
  input  wire logic signed [chull_pkg::COORD_BITS-1:0] point_x,
  input  wire logic signed [chull_pkg::COORD_BITS-1:0] point_y,
  input  wire logic                                    last_point,
  output logic                                         result_valid,
  output logic signed [chull_pkg::COORD_BITS-1:0]      hull_x,
  output logic signed [chull_pkg::COORD_BITS-1:0]      hull_y,
  output logic                                         overflow,
  output logic                                         last_vertex
);

  chull_pkg::chull_cmd_t  cmd;
  chull_pkg::chull_stat_t stat;

  chull_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .last_point (last_point),
    .busy       (busy),
    .cmd        (cmd),
    .stat       (stat)
  );

  chull_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .point_x      (point_x),
    .point_y      (point_y),
    .cmd          (cmd),
    .stat         (stat),
    .hull_x       (hull_x),
    .hull_y       (hull_y),
    .overflow     (overflow),
    .last_vertex  (last_vertex),
    .result_valid (result_valid)
  );

endmodule
`default_nettype wire

FILE: design/chull_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module chull_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read the array
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: design/chull_ctrl.sv
// Controller: load, insertion sort, monotone chain and emission sequencing.
`default_nettype none
module chull_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic                 last_point,
  output logic                      busy,
  output chull_pkg::chull_cmd_t     cmd,
  input  wire chull_pkg::chull_stat_t stat
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRT_RD,
    S_SRT_GET,
    S_SRT_CMP,
    S_SRT_PUT,
    S_HL_RD,
    S_HL_GET,
    S_HL_CHK,
    S_HL_X,
    S_HL_POPW,
    S_HL_PUSH,
    S_EM_RD,
    S_EM_OUT
  } state_t;

  state_t                          state;
  logic [chull_pkg::CNT_W-1:0]     n;
  logic [chull_pkg::CNT_W-1:0]     i;
  logic [chull_pkg::AW-1:0]        j;
  logic [chull_pkg::AW-1:0]        idx;
  logic [chull_pkg::CNT_W-1:0]     k;
  logic [chull_pkg::CNT_W-1:0]     cnt;
  logic [chull_pkg::TOP_W-1:0]     floor_top;
  logic                            upper;
  logic                            em_hull;
  logic                            ovf;
  logic                            accept;
  logic                            room;
  logic [chull_pkg::CNT_W-1:0]     n_next;
  logic                            em_last;

  assign busy    = (state != S_IDLE);
  assign accept  = start && !busy;
  assign room    = (n < chull_pkg::CNT_W'(chull_pkg::MAX_POINTS));
  assign n_next  = room ? n + 1'b1 : n;
  assign em_last = ((k + 1'b1) == cnt);

  // Decode commands from state
  always_comb begin
    cmd          = '0;
    cmd.st_wsrc  = chull_pkg::WD_IN;
    cmd.out_ovf  = ovf;
    cmd.out_last = em_last;
    cmd.out_hull = em_hull;
    unique case (state)
      S_IDLE: begin
        cmd.st_we = accept && room;
        cmd.st_wa = n[chull_pkg::AW-1:0];
      end
      S_SRT_RD: begin
        cmd.st_ra = i[chull_pkg::AW-1:0];
      end
      S_SRT_GET: begin
        cmd.p_ld  = 1'b1;
        cmd.st_ra = chull_pkg::AW'(i - 1'b1);
      end
      S_SRT_CMP: begin
        cmd.st_we   = stat.lt;
        cmd.st_wa   = j;
        cmd.st_wsrc = chull_pkg::WD_RD;
        cmd.st_ra   = j - 2'd2;
      end
      S_SRT_PUT: begin
        cmd.st_we   = 1'b1;
        cmd.st_wa   = j;
        cmd.st_wsrc = chull_pkg::WD_P;
        cmd.top_clr = (i == (n - 1'b1));
      end
      S_HL_RD: begin
        cmd.st_ra = idx;
      end
      S_HL_GET: begin
        cmd.p_ld = 1'b1;
      end
      S_HL_CHK: begin
      end
      S_HL_X: begin
        cmd.pop   = stat.pop_ok;
        cmd.hs_ra = chull_pkg::HAW'(stat.top - 2'd3);
      end
      S_HL_POPW: begin
        cmd.t2_ld = 1'b1;
      end
      S_HL_PUSH: begin
        cmd.push = 1'b1;
      end
      S_EM_RD: begin
        cmd.st_ra = k[chull_pkg::AW-1:0];
        cmd.hs_ra = chull_pkg::HAW'(k);
      end
      S_EM_OUT: begin
        cmd.out_ld = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Advance state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      n     <= '0;
      ovf   <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            n <= n_next;
            if (!room) begin
              ovf <= 1'b1;
            end
            if (last_point) begin
              if (n_next <= chull_pkg::CNT_W'(chull_pkg::ECHO_LIMIT)) begin
                k       <= '0;
                cnt     <= n_next;
                em_hull <= 1'b0;
                state   <= S_EM_RD;
              end else begin
                i     <= chull_pkg::CNT_W'(1);
                state <= S_SRT_RD;
              end
            end
          end
        end
        S_SRT_RD: state <= S_SRT_GET;
        S_SRT_GET: begin
          j     <= i[chull_pkg::AW-1:0];
          state <= S_SRT_CMP;
        end
        S_SRT_CMP: begin
          if (stat.lt) begin
            j <= j - 1'b1;
            if (j == chull_pkg::AW'(1)) begin
              state <= S_SRT_PUT;
            end
          end else begin
            state <= S_SRT_PUT;
          end
        end
        S_SRT_PUT: begin
          if (i == (n - 1'b1)) begin
            idx       <= '0;
            upper     <= 1'b0;
            floor_top <= chull_pkg::TOP_W'(2);
            state     <= S_HL_RD;
          end else begin
            i     <= i + 1'b1;
            state <= S_SRT_RD;
          end
        end
        S_HL_RD:  state <= S_HL_GET;
        S_HL_GET: state <= S_HL_CHK;
        S_HL_CHK: begin
          state <= (stat.top >= floor_top) ? S_HL_X : S_HL_PUSH;
        end
        S_HL_X: begin
          state <= stat.pop_ok ? S_HL_POPW : S_HL_PUSH;
        end
        S_HL_POPW: state <= S_HL_CHK;
        S_HL_PUSH: begin
          if (!upper) begin
            if ({1'b0, idx} == (n - 1'b1)) begin
              upper     <= 1'b1;
              floor_top <= stat.top + 2'd2;
              idx       <= chull_pkg::AW'(n - 2'd2);
            end else begin
              idx <= idx + 1'b1;
            end
            state <= S_HL_RD;
          end else if (idx == '0) begin
            k       <= '0;
            em_hull <= 1'b1;
            cnt     <= (stat.top > chull_pkg::TOP_W'(chull_pkg::MAX_POINTS)) ?
                       chull_pkg::CNT_W'(chull_pkg::MAX_POINTS) :
                       stat.top[chull_pkg::CNT_W-1:0];
            state   <= S_EM_RD;
          end else begin
            idx   <= idx - 1'b1;
            state <= S_HL_RD;
          end
        end
        S_EM_RD: state <= S_EM_OUT;
        S_EM_OUT: begin
          if (em_last) begin
            n     <= '0;
            ovf   <= 1'b0;
            state <= S_IDLE;
          end else begin
            k     <= k + 1'b1;
            state <= S_EM_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: design/chull_dp.sv
// Datapath: point store, hull stack, sort compare, cross product, result registers.
`default_nettype none
module chull_dp (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic signed [chull_pkg::COORD_BITS-1:0] point_x,
  input  wire logic signed [chull_pkg::COORD_BITS-1:0] point_y,
  input  wire chull_pkg::chull_cmd_t                 cmd,
  output chull_pkg::chull_stat_t                     stat,
  output logic signed [chull_pkg::COORD_BITS-1:0]    hull_x,
  output logic signed [chull_pkg::COORD_BITS-1:0]    hull_y,
  output logic                                       overflow,
  output logic                                       last_vertex,
  output logic                                       result_valid
);

  localparam int CB = chull_pkg::COORD_BITS;
  localparam int PW = chull_pkg::PT_W;
  localparam int DW = chull_pkg::DIFF_W;
  localparam int QW = chull_pkg::PROD_W;

  logic [PW-1:0]                   st_wd;
  logic [PW-1:0]                   st_rd;
  logic [PW-1:0]                   hs_rd;
  logic [PW-1:0]                   p;
  logic [PW-1:0]                   t1;
  logic [PW-1:0]                   t2;
  logic [chull_pkg::TOP_W-1:0]     top;
  logic signed [CB-1:0]            px, py, qx, qy, ax, ay, ox, oy;
  logic signed [DW-1:0]            dax, day, dbx, dby;
  logic signed [QW-1:0]            prod_a, prod_b;
  logic signed [QW:0]              cross_val;
  logic [PW-1:0]                   out_pt;

  // Select store write data
  always_comb begin
    case (cmd.st_wsrc)
      chull_pkg::WD_IN: st_wd = {point_x, point_y};
      chull_pkg::WD_RD: st_wd = st_rd;
      chull_pkg::WD_P:  st_wd = p;
      default:          st_wd = p;
    endcase
  end

  chull_ram #(.WIDTH(PW), .DEPTH(chull_pkg::MAX_POINTS)) u_store (
    .clk   (clk),
    .we    (cmd.st_we),
    .waddr (cmd.st_wa),
    .wdata (st_wd),
    .raddr (cmd.st_ra),
    .rdata (st_rd)
  );

  chull_ram #(.WIDTH(PW), .DEPTH(chull_pkg::STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (top[chull_pkg::HAW-1:0]),
    .wdata (p),
    .raddr (cmd.hs_ra),
    .rdata (hs_rd)
  );

  assign px = p[PW-1:CB];
  assign py = p[CB-1:0];
  assign qx = st_rd[PW-1:CB];
  assign qy = st_rd[CB-1:0];
  assign ax = t1[PW-1:CB];
  assign ay = t1[CB-1:0];
  assign ox = t2[PW-1:CB];
  assign oy = t2[CB-1:0];

  // Order test: held point before the point just read
  assign stat.lt = (px < qx) || ((px == qx) && (py < qy));

  // Cross product (A-O) x (P-O), products registered
  assign dax = DW'(ax) - DW'(ox);
  assign day = DW'(ay) - DW'(oy);
  assign dbx = DW'(px) - DW'(ox);
  assign dby = DW'(py) - DW'(oy);

  always_ff @(posedge clk) begin
    prod_a <= dax * dby;
    prod_b <= day * dbx;
  end

  assign cross_val   = (QW + 1)'(prod_a) - (QW + 1)'(prod_b);
  assign stat.pop_ok = cross_val[QW] || (cross_val == '0);
  assign stat.top    = top;

  // Hold point, stack top cache and stack pointer
  always_ff @(posedge clk) begin
    if (cmd.p_ld) begin
      p <= st_rd;
    end
    if (cmd.push) begin
      t2 <= t1;
      t1 <= p;
    end else if (cmd.pop) begin
      t1 <= t2;
    end else if (cmd.t2_ld) begin
      t2 <= hs_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      top <= '0;
    end else if (cmd.top_clr) begin
      top <= '0;
    end else if (cmd.push) begin
      top <= top + 1'b1;
    end else if (cmd.pop) begin
      top <= top - 1'b1;
    end
  end

  // Register the result
  assign out_pt = cmd.out_hull ? hs_rd : st_rd;

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      hull_x      <= out_pt[PW-1:CB];
      hull_y      <= out_pt[CB-1:0];
      overflow    <= cmd.out_ovf;
      last_vertex <= cmd.out_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.out_ld;
    end
  end

endmodule
`default_nettype wire

FILE: design/chull_checker.sv
// Port-level checker for the convex hull block, bound to the top level.
`default_nettype none
`include "convex_hull_2d_top_defines.svh"
module chull_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic last_point,
  input wire logic result_valid,
  input wire logic last_vertex
);

  // A non-final result is followed by more work
  `CHULL_ASSERT_NOW(a_mid_busy, result_valid && !last_vertex, busy)
  // A non-final point leaves the block ready
  `CHULL_ASSERT_NEXT(a_load_idle, start && !busy && !last_point, !busy)
  // A final point starts processing
  `CHULL_ASSERT_NEXT(a_last_busy, start && !busy && last_point, busy)
  // The final vertex closes the run
  `CHULL_ASSERT_NEXT(a_end_quiet, result_valid && last_vertex, !result_valid)

endmodule

bind convex_hull_2d_top chull_checker u_chull_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .last_point   (last_point),
  .result_valid (result_valid),
  .last_vertex  (last_vertex)
);
`default_nettype wire
